[hw/rtl/arwt_pkg.sv]
// ----------------------------------------------------------------------------
// arwt_pkg
// Shared constants, codes and types of the address range watch table.
// ----------------------------------------------------------------------------
package arwt_pkg;

    localparam int ENTRIES = 16;
    localparam int OWNERS  = 8;

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int ADDR_W  = 32;
    localparam int OWNER_W = 3;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;
    localparam int EN_W    = 8;

    localparam int BUCKET_SHIFT = 12;
    localparam int BUCKET_W     = 10;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_REMALL = 2'd2;
    localparam logic [1:0] OP_LOOKUP = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  length;
        logic [OWNER_W-1:0] owner;
        logic [IDX_W-1:0]   age;
    } entry_t;

    typedef struct packed {
        logic               add_en;
        logic [ADDR_W-1:0]  add_base;
        logic [ADDR_W-1:0]  add_length;
        logic [OWNER_W-1:0] add_owner;
        logic               free_en;
    } store_cmd_t;

    typedef struct packed {
        logic               full;
        logic [IDX_W-1:0]   free_idx;
    } store_stat_t;

endpackage

[hw/rtl/arwt_entry_store.sv]
// ----------------------------------------------------------------------------
// arwt_entry_store
// Range table: valid bits, base, length, owner and newness rank per slot.
// One read port at the sequencer index; add fills the lowest free slot,
// free clears the slot at the read index and closes the gap in the ranks.
// ----------------------------------------------------------------------------
module arwt_entry_store
    import arwt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] rd_idx,
    input  store_cmd_t       cmd,
    output entry_t           rd_entry,
    output store_stat_t      stat
);

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [ADDR_W-1:0]  base_reg   [ENTRIES];
    logic [ADDR_W-1:0]  length_reg [ENTRIES];
    logic [OWNER_W-1:0] owner_reg  [ENTRIES];
    logic [IDX_W-1:0]   age_reg    [ENTRIES];
    logic [IDX_W-1:0]   free_idx;
    logic               full;

    // Lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
        full = &valid_reg;
    end

    assign stat.full     = full;
    assign stat.free_idx = free_idx;

    assign rd_entry.valid  = valid_reg[rd_idx];
    assign rd_entry.base   = base_reg[rd_idx];
    assign rd_entry.length = length_reg[rd_idx];
    assign rd_entry.owner  = owner_reg[rd_idx];
    assign rd_entry.age    = age_reg[rd_idx];

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.add_en && !full)
        begin
            valid_next[free_idx] = 1'b1;
        end
        if (cmd.free_en)
        begin
            valid_next[rd_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add_en && !full)
        begin
            // Age every live range, then place the new one as newest
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (valid_reg[i])
                begin
                    age_reg[i] <= age_reg[i] + 1'b1;
                end
            end
            base_reg[free_idx]   <= cmd.add_base;
            length_reg[free_idx] <= cmd.add_length;
            owner_reg[free_idx]  <= cmd.add_owner;
            age_reg[free_idx]    <= '0;
        end
        else if (cmd.free_en)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (valid_reg[i] && (age_reg[i] > age_reg[rd_idx]))
                begin
                    age_reg[i] <= age_reg[i] - 1'b1;
                end
            end
        end
    end

endmodule

[hw/rtl/arwt_match_unit.sv]
// ----------------------------------------------------------------------------
// arwt_match_unit
// Overlap check of one stored range against the access, shared by all slots
// over the scan: same bucket, and neither range ends at or before the other
// starts (32-bit wrapping sums).
// ----------------------------------------------------------------------------
module arwt_match_unit
    import arwt_pkg::*;
(
    input  logic [ADDR_W-1:0] base,
    input  logic [ADDR_W-1:0] length,
    input  logic [ADDR_W-1:0] acc_addr,
    input  logic [ADDR_W-1:0] acc_size,
    output logic              overlap
);

    logic [ADDR_W-1:0]   range_end;
    logic [ADDR_W-1:0]   acc_end;
    logic [BUCKET_W-1:0] base_bucket;
    logic [BUCKET_W-1:0] acc_bucket;

    assign range_end   = base + length;
    assign acc_end     = acc_addr + acc_size;
    assign base_bucket = base[BUCKET_SHIFT +: BUCKET_W];
    assign acc_bucket  = acc_addr[BUCKET_SHIFT +: BUCKET_W];

    assign overlap = (base_bucket == acc_bucket)
                  && !(range_end <= acc_addr)
                  && !(acc_end <= base);

endmodule

[hw/rtl/address_range_watch_table.sv]
// ----------------------------------------------------------------------------
// address_range_watch_table
// Table of watched address ranges with add, remove, remove-all and lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries op, addr, length, owner, slot.
//   Output channel (out_valid/out_ready) returns one item per input item:
//   hit, matched, result_slot, removed_count, status.
//   Config channel (cfg_valid/cfg_ready) writes owner_enable; always ready;
//   the user keeps it written only while the table is idle (unchecked).
// Timing:
//   An add or remove passes through S_ADD or S_REM and then S_FIN, from
//   which the result is registered to the output. Lookup and remove-all
//   walk all ENTRIES slots through one overlap/owner compare unit, one slot
//   per cycle, then pass to S_FIN. in_ready returns with the result, so a
//   new item is taken only once the last one's result has been registered.
// Reset clears all valid bits and owner_enable. A stalled receiver holds
// the result register; one more item may be accepted and worked on, and it
// waits in its final step until the output register is free.
// ----------------------------------------------------------------------------
module address_range_watch_table
    import arwt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [EN_W-1:0]    cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [ADDR_W-1:0]  addr,
    input  logic [ADDR_W-1:0]  length,
    input  logic [OWNER_W-1:0] owner,
    input  logic [SLOT_W-1:0]  slot,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic               matched,
    output logic [SLOT_W-1:0]  result_slot,
    output logic [COUNT_W-1:0] removed_count,
    output logic [1:0]         status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_REM  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [EN_W-1:0]    owner_enable_reg;

    logic [1:0]         op_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  length_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic [SLOT_W-1:0]  slot_reg;

    logic               found_reg, found_next;
    logic [IDX_W-1:0]   best_age_reg, best_age_next;
    logic [OWNER_W-1:0] best_owner_reg, best_owner_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [1:0]         res_status_reg, res_status_next;

    logic               out_valid_reg;
    logic               hit_reg;
    logic               matched_reg;
    logic [SLOT_W-1:0]  result_slot_reg;
    logic [COUNT_W-1:0] removed_count_reg;
    logic [1:0]         status_reg;

    entry_t             rd_entry;
    store_cmd_t         cmd;
    store_stat_t        stat;
    logic [IDX_W-1:0]   rd_idx;
    logic               overlap;
    logic               slot_in_range;
    logic               accept;
    logic               out_free;
    logic               best_on;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    assign cfg_ready = 1'b1;

    assign slot_in_range = (32'(slot_reg) < ENTRIES);
    assign rd_idx = (state_reg == S_REM) ? IDX_W'(slot_reg) : idx_reg;

    arwt_entry_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (rd_idx),
        .cmd      (cmd),
        .rd_entry (rd_entry),
        .stat     (stat)
    );

    arwt_match_unit u_match (
        .base     (rd_entry.base),
        .length   (rd_entry.length),
        .acc_addr (addr_reg),
        .acc_size (length_reg),
        .overlap  (overlap)
    );

    assign best_on = (32'(best_owner_reg) < OWNERS) && owner_enable_reg[best_owner_reg];

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        best_age_next   = best_age_reg;
        best_owner_next = best_owner_reg;
        res_slot_next   = res_slot_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;

        cmd.add_en     = 1'b0;
        cmd.add_base   = addr_reg;
        cmd.add_length = length_reg;
        cmd.add_owner  = owner_reg;
        cmd.free_en    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next        = '0;
                    found_next      = 1'b0;
                    res_slot_next   = '0;
                    count_next      = '0;
                    res_status_next = STATUS_OK;
                    case (op)
                        OP_ADD:    state_next = S_ADD;
                        OP_REMOVE: state_next = S_REM;
                        default:   state_next = S_SCAN;
                    endcase
                end
            end
            S_ADD:
            begin
                cmd.add_en = 1'b1;
                if (stat.full)
                begin
                    res_status_next = STATUS_FULL;
                end
                else
                begin
                    res_slot_next = SLOT_W'(stat.free_idx);
                end
                state_next = S_FIN;
            end
            S_REM:
            begin
                res_slot_next = slot_reg;
                if (slot_in_range && rd_entry.valid)
                begin
                    cmd.free_en = 1'b1;
                end
                else
                begin
                    res_status_next = STATUS_EMPTY;
                end
                state_next = S_FIN;
            end
            S_SCAN:
            begin
                if (op_reg == OP_LOOKUP)
                begin
                    // Keep the newest overlapping range
                    if (rd_entry.valid && overlap
                        && (!found_reg || (rd_entry.age < best_age_reg)))
                    begin
                        found_next      = 1'b1;
                        best_age_next   = rd_entry.age;
                        best_owner_next = rd_entry.owner;
                        res_slot_next   = SLOT_W'(idx_reg);
                    end
                end
                else if (rd_entry.valid && (rd_entry.owner == owner_reg))
                begin
                    cmd.free_en = 1'b1;
                    count_next  = count_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            owner_enable_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cfg_valid && cfg_ready)
            begin
                owner_enable_reg <= cfg_data;
            end
            if ((state_reg == S_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op;
            addr_reg   <= addr;
            length_reg <= length;
            owner_reg  <= owner;
            slot_reg   <= slot;
        end
        found_reg      <= found_next;
        best_age_reg   <= best_age_next;
        best_owner_reg <= best_owner_next;
        res_slot_reg   <= res_slot_next;
        count_reg      <= count_next;
        res_status_reg <= res_status_next;

        if ((state_reg == S_FIN) && out_free)
        begin
            if (op_reg == OP_LOOKUP)
            begin
                matched_reg     <= found_reg;
                hit_reg         <= found_reg && best_on;
                result_slot_reg <= found_reg ? res_slot_reg : '0;
            end
            else
            begin
                matched_reg     <= 1'b0;
                hit_reg         <= 1'b0;
                result_slot_reg <= res_slot_reg;
            end
            removed_count_reg <= COUNT_W'(count_reg);
            status_reg        <= res_status_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign matched       = matched_reg;
    assign result_slot   = result_slot_reg;
    assign removed_count = removed_count_reg;
    assign status        = status_reg;

endmodule
